// File: rtl/core/msnp_pkg.sv
// Shared constants and types for the MIDI note span pairing block.
package msnp_pkg;

  localparam int KEY_COUNT   = 128;
  localparam int KEY_WIDTH   = 7;
  localparam int VEL_WIDTH   = 7;
  localparam int CHAN_WIDTH  = 4;
  localparam int EPOCH_WIDTH = 8;

  localparam logic [7:0] TYPE_MASK     = 8'hF0;
  localparam logic [7:0] CHAN_MASK     = 8'h0F;
  localparam logic [7:0] TYPE_NOTE_ON  = 8'h90;
  localparam logic [7:0] TYPE_NOTE_OFF = 8'h80;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic {
    MODE_SWEEP,
    MODE_RUN
  } mode_t;

endpackage

// File: rtl/core/msnp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msnp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first: a same-edge write is not seen
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/midi_note_span_pairing_top.sv
// Top level of the MIDI note span pairing block.
//
// Input channel (in_valid/in_ready) carries one MIDI event per transfer: a
// command bit (event or clear-all), status byte, key, velocity and tick.
// Output channel (out_valid/out_ready) carries one note span per transfer.
// An event is read from the slot memory at its transfer edge and resolved
// in the resolve stage; when that stage advances, the slot is written back
// and any span is loaded into the output register that drives out_valid.
// One event per cycle is sustained while the output is not stalled and no
// sweep runs; a forwarding register covers back-to-back hits on the same
// slot in its read-modify-write.
// Clear-all bumps an epoch tag kept with every slot, so it writes no slot.
// Every 2**EPOCH_WIDTH clears, and after reset, a sweep writes all
// CHANNEL_COUNT*128 slots (2048 by default) closed, one per cycle, while
// in_ready stays low.
// When out_ready is low, the output register holds its span, one more event
// is taken into the resolve stage and then in_ready drops until it drains.
module midi_note_span_pairing_top #(
  parameter int CHANNEL_COUNT = 16,
  parameter int TICK_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  status_byte,
  input  logic [msnp_pkg::KEY_WIDTH-1:0] key_number,
  input  logic [msnp_pkg::VEL_WIDTH-1:0] key_velocity,
  input  logic [31:0] event_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] span_start,
  output logic [31:0] span_end,
  output logic [msnp_pkg::KEY_WIDTH-1:0]  span_pitch,
  output logic [msnp_pkg::VEL_WIDTH-1:0]  span_velocity,
  output logic [msnp_pkg::CHAN_WIDTH-1:0] span_channel
);

  import msnp_pkg::*;

  localparam int DEPTH = CHANNEL_COUNT * KEY_COUNT;
  localparam int AW    = $clog2(DEPTH);

  typedef struct packed {
    logic                   open;
    logic [EPOCH_WIDTH-1:0] tag;
    logic [TICK_WIDTH-1:0]  start;
    logic [VEL_WIDTH-1:0]   vel;
  } entry_t;

  localparam int EW = $bits(entry_t);

  mode_t mode, mode_next;
  logic  sweeping;
  logic  sweep_last;
  logic [AW-1:0] sweep_cnt;
  logic [EPOCH_WIDTH-1:0] epoch;
  logic  epoch_wrap;

  // resolve stage
  logic                  s1_valid;
  logic                  s1_cmd;
  logic [7:0]            s1_status;
  logic [KEY_WIDTH-1:0]  s1_key;
  logic [VEL_WIDTH-1:0]  s1_vel;
  logic [TICK_WIDTH-1:0] s1_tick;
  logic [AW-1:0]         s1_addr;
  logic                  s1_adv;

  logic in_fire;
  logic [KEY_WIDTH+CHAN_WIDTH-1:0] in_slot;

  // memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  // last write, for a read that raced it
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  entry_t        fwd_data;

  entry_t cur;
  logic   is_open;
  logic   chan_ok;
  logic   is_on;
  logic   is_off;
  logic   do_write;
  logic   do_emit;
  entry_t new_entry;

  assign in_fire = in_valid && in_ready;
  assign in_slot = {status_byte[CHAN_WIDTH-1:0], key_number};

  // ---------------- sweep control ----------------
  assign sweep_last = (sweep_cnt == AW'(DEPTH - 1));
  assign epoch_wrap = (epoch == {EPOCH_WIDTH{1'b1}});

  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_SWEEP: if (sweep_last) mode_next = MODE_RUN;
      MODE_RUN:   if (s1_adv && s1_cmd && epoch_wrap) mode_next = MODE_SWEEP;
      default:    mode_next = MODE_SWEEP;
    endcase
  end

  always_comb begin
    unique case (mode)
      MODE_SWEEP: sweeping = 1'b1;
      MODE_RUN:   sweeping = 1'b0;
      default:    sweeping = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_SWEEP;
      sweep_cnt <= '0;
      epoch     <= '0;
    end else begin
      mode <= mode_next;
      if (sweeping) begin
        sweep_cnt <= sweep_last ? '0 : sweep_cnt + 1'b1;
      end
      if (s1_adv && s1_cmd) begin
        epoch <= epoch + 1'b1;
      end
    end
  end

  // ---------------- handshake ----------------
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  // nothing may follow a clear that will start a sweep
  assign in_ready = !sweeping && !(s1_valid && s1_cmd && epoch_wrap)
                    && (!s1_valid || s1_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd    <= command;
      s1_status <= status_byte;
      s1_key    <= key_number;
      s1_vel    <= key_velocity;
      s1_tick   <= event_tick[TICK_WIDTH-1:0];
      s1_addr   <= AW'(in_slot);
    end
  end

  // ---------------- slot memory ----------------
  msnp_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_fire),
    .raddr(AW'(in_slot)),
    .rdata(ram_rdata)
  );

  // ---------------- resolve ----------------
  always_comb begin
    cur     = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : ram_rdata;
    is_open = cur.open && (cur.tag == epoch);
    chan_ok = ({4'd0, s1_status & CHAN_MASK} < 12'(CHANNEL_COUNT));
    is_on   = ((s1_status & TYPE_MASK) == TYPE_NOTE_ON);
    is_off  = ((s1_status & TYPE_MASK) == TYPE_NOTE_OFF);

    do_write  = 1'b0;
    do_emit   = 1'b0;
    new_entry = cur;
    if (s1_cmd == CMD_EVENT && chan_ok) begin
      if (is_on && s1_vel != '0) begin
        do_write        = 1'b1;
        do_emit         = is_open;
        new_entry.open  = 1'b1;
        new_entry.tag   = epoch;
        new_entry.start = s1_tick;
        new_entry.vel   = s1_vel;
      end else if ((is_on || is_off) && is_open) begin
        do_write       = 1'b1;
        do_emit        = 1'b1;
        new_entry.open = 1'b0;
      end
    end
  end

  always_comb begin
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && do_write;
      ram_waddr = s1_addr;
      ram_wdata = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (ram_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= do_emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && do_emit) begin
      span_start    <= 32'(cur.start);
      span_end      <= 32'(s1_tick);
      span_pitch    <= s1_key;
      span_velocity <= cur.vel;
      span_channel  <= s1_status[CHAN_WIDTH-1:0];
    end
  end

endmodule

// File: tb/midi_note_span_pairing_top_tb.sv
// Testbench for the MIDI note span pairing block: directed and random events, span prediction, checks.
module midi_note_span_pairing_top_tb;
  import msnp_pkg::*;

  localparam int CHANNEL_COUNT = 16;
  localparam int TICK_WIDTH    = 32;
  localparam int SLOT_COUNT    = CHANNEL_COUNT * KEY_COUNT;
  localparam logic [31:0] TICK_MASK = 32'((64'd1 << TICK_WIDTH) - 64'd1);
  localparam int CYCLE_LIMIT   = 300000;
  localparam int POOL_SIZE     = 8;
  localparam int TAIL_CYCLES   = 10;

  // event types the block must ignore
  localparam logic [7:0] TYPE_POLY_PRESSURE = 8'hA0;
  localparam logic [7:0] TYPE_CONTROL       = 8'hB0;
  localparam logic [7:0] TYPE_PITCH_BEND    = 8'hE0;
  localparam logic [7:0] TYPE_SYSTEM        = 8'hF0;

  typedef struct packed {
    logic [31:0]           start_tick;
    logic [31:0]           end_tick;
    logic [KEY_WIDTH-1:0]  pitch;
    logic [VEL_WIDTH-1:0]  velocity;
    logic [CHAN_WIDTH-1:0] channel;
  } note_span_t;

  class note_span_tracker;
    bit                   open_flag [SLOT_COUNT];
    logic [31:0]          open_tick [SLOT_COUNT];
    logic [VEL_WIDTH-1:0] open_vel  [SLOT_COUNT];
    note_span_t           expected_spans[$];
    int unsigned          fail_count;

    function new();
      foreach (open_flag[i]) open_flag[i] = 1'b0;
      fail_count = 0;
    endfunction

    function int unsigned pending();
      return expected_spans.size();
    endfunction

    // predicts the span (if any) caused by one accepted event
    function void take_event(logic cmd, logic [7:0] status, logic [KEY_WIDTH-1:0] key,
                             logic [VEL_WIDTH-1:0] vel, logic [31:0] tick);
      logic [7:0]  kind;
      logic [7:0]  chan;
      logic [31:0] t;
      int          slot;
      note_span_t  span;
      kind = status & TYPE_MASK;
      chan = status & CHAN_MASK;
      t    = tick & TICK_MASK;
      if (cmd == CMD_CLEAR) begin
        foreach (open_flag[i]) open_flag[i] = 1'b0;
        return;
      end
      if (int'(chan) >= CHANNEL_COUNT) return;
      slot = int'(chan) * KEY_COUNT + int'(key);
      span.start_tick = open_tick[slot];
      span.end_tick   = t;
      span.pitch      = key;
      span.velocity   = open_vel[slot];
      span.channel    = chan[CHAN_WIDTH-1:0];
      if (kind == TYPE_NOTE_ON && vel != '0) begin
        if (open_flag[slot]) expected_spans = {expected_spans, span};
        open_flag[slot] = 1'b1;
        open_tick[slot] = t;
        open_vel[slot]  = vel;
      end else if ((kind == TYPE_NOTE_OFF || kind == TYPE_NOTE_ON) && open_flag[slot]) begin
        expected_spans = {expected_spans, span};
        open_flag[slot] = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        fail_count++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_span(note_span_t got);
      note_span_t want;
      if (expected_spans.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected span, expected none actual %h", $time, got);
        return;
      end
      want = expected_spans.pop_front();
      compare_field("span_start", want.start_tick, got.start_tick);
      compare_field("span_end", want.end_tick, got.end_tick);
      compare_field("span_pitch", 32'(want.pitch), 32'(got.pitch));
      compare_field("span_velocity", 32'(want.velocity), 32'(got.velocity));
      compare_field("span_channel", 32'(want.channel), 32'(got.channel));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  command = CMD_EVENT;
  logic [7:0]            status_byte = '0;
  logic [KEY_WIDTH-1:0]  key_number = '0;
  logic [VEL_WIDTH-1:0]  key_velocity = '0;
  logic [31:0]           event_tick = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           span_start;
  logic [31:0]           span_end;
  logic [KEY_WIDTH-1:0]  span_pitch;
  logic [VEL_WIDTH-1:0]  span_velocity;
  logic [CHAN_WIDTH-1:0] span_channel;

  bit                    calm = 1'b0;
  int unsigned           cycle_count = 0;
  logic [31:0]           now_tick = '0;
  logic [CHAN_WIDTH-1:0] pool_chan [POOL_SIZE];
  logic [KEY_WIDTH-1:0]  pool_key  [POOL_SIZE];
  note_span_tracker      tracker = new();

  midi_note_span_pairing_top #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .TICK_WIDTH   (TICK_WIDTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .status_byte  (status_byte),
    .key_number   (key_number),
    .key_velocity (key_velocity),
    .event_tick   (event_tick),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .span_start   (span_start),
    .span_end     (span_end),
    .span_pitch   (span_pitch),
    .span_velocity(span_velocity),
    .span_channel (span_channel)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("midi_note_span_pairing_top_tb failed");
    $finish;
  end

  // span receiver with random backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        tracker.check_span({span_start, span_end, span_pitch, span_velocity, span_channel});
      out_ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  task automatic send_event(logic cmd, logic [7:0] status, logic [KEY_WIDTH-1:0] key,
                            logic [VEL_WIDTH-1:0] vel, logic [31:0] tick);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    status_byte  <= status;
    key_number   <= key;
    key_velocity <= vel;
    event_tick   <= tick;
    do @(posedge clk); while (!in_ready);
    tracker.take_event(cmd, status, key, vel, tick);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] next_tick();
    if ($urandom_range(19) == 0) return $urandom;
    now_tick += $urandom_range(0, 500);
    return now_tick;
  endfunction

  task automatic send_clear();
    send_event(CMD_CLEAR, 8'($urandom), 7'($urandom), 7'($urandom), $urandom);
  endtask

  task automatic play_random_event();
    int unsigned           pick;
    int unsigned           idx;
    logic [CHAN_WIDTH-1:0] ch;
    logic [KEY_WIDTH-1:0]  key;
    logic [7:0]            st;
    pick = $urandom_range(99);
    idx  = $urandom_range(POOL_SIZE - 1);
    // mostly a small set of slots so notes actually pair up
    if ($urandom_range(9) < 7) begin
      ch  = pool_chan[idx];
      key = pool_key[idx];
    end else begin
      ch  = 4'($urandom);
      key = 7'($urandom);
    end
    if (pick < 40)
      send_event(CMD_EVENT, TYPE_NOTE_ON | 8'(ch), key, 7'($urandom_range(1, 127)), next_tick());
    else if (pick < 65)
      send_event(CMD_EVENT, TYPE_NOTE_OFF | 8'(ch), key, 7'($urandom), next_tick());
    else if (pick < 77)
      send_event(CMD_EVENT, TYPE_NOTE_ON | 8'(ch), key, '0, next_tick());
    else if (pick < 80)
      send_clear();
    else if (pick < 90) begin
      st = 8'($urandom);
      // steer away from note types
      if ((st & TYPE_MASK) == TYPE_NOTE_ON || (st & TYPE_MASK) == TYPE_NOTE_OFF)
        st = st ^ 8'h20;
      send_event(CMD_EVENT, st, key, 7'($urandom), next_tick());
    end else
      send_event(CMD_EVENT, 8'($urandom), key, 7'($urandom), $urandom);
    if ($urandom_range(49) == 0) begin
      pool_chan[idx] = 4'($urandom);
      pool_key[idx]  = 7'($urandom);
    end
  endtask

  initial begin
    foreach (pool_chan[i]) begin
      pool_chan[i] = 4'($urandom);
      pool_key[i]  = 7'($urandom);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, reopen, closes, ignored types, clear
    send_event(CMD_EVENT, TYPE_NOTE_ON,         7'd0,   7'd127, 32'h0000_0000);
    send_event(CMD_EVENT, TYPE_NOTE_OFF,        7'd0,   7'd0,   32'hFFFF_FFFF);
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h0F, 7'd127, 7'd1,   32'hFFFF_FFFF);
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h0F, 7'd127, 7'd127, 32'h0000_0005);
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h0F, 7'd127, 7'd0,   32'h8000_0000);
    send_event(CMD_EVENT, TYPE_NOTE_OFF | 8'h0F, 7'd127, 7'd64, 32'h0000_0010);
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h03, 7'd64,  7'd0,   32'h0000_0011);
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h03, 7'd64,  7'd64,  32'h0000_0012);
    send_event(CMD_EVENT, TYPE_POLY_PRESSURE | 8'h03, 7'd64, 7'd99, 32'h0000_0013);
    send_event(CMD_EVENT, TYPE_CONTROL | 8'h03, 7'd64,  7'd127, 32'h0000_0014);
    send_event(CMD_EVENT, TYPE_PITCH_BEND | 8'h03, 7'd64, 7'd1, 32'h0000_0015);
    send_event(CMD_EVENT, TYPE_SYSTEM | 8'h0F,  7'd64,  7'd127, 32'h0000_0016);
    send_event(CMD_EVENT, 8'h00,                7'd64,  7'd127, 32'h0000_0017);
    // same key, other channel: a separate slot
    send_event(CMD_EVENT, TYPE_NOTE_OFF | 8'h04, 7'd64, 7'd10,  32'h0000_0018);
    send_event(CMD_EVENT, TYPE_NOTE_OFF | 8'h03, 7'd64, 7'd127, 32'h0000_0019);
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h07, 7'd42,  7'd90,  32'h1234_5678);
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h08, 7'd43,  7'd91,  32'h1234_5679);
    send_event(CMD_CLEAR, TYPE_NOTE_OFF | 8'h07, 7'd42, 7'd127, 32'hFFFF_FFFF);
    send_event(CMD_EVENT, TYPE_NOTE_OFF | 8'h07, 7'd42, 7'd0,   32'h1234_5680);
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h08, 7'd43,  7'd5,   32'h1234_5681);
    send_event(CMD_EVENT, TYPE_NOTE_OFF | 8'h08, 7'd43, 7'd0,   32'h1234_5682);
    send_event(CMD_CLEAR, 8'hFF,                7'd127, 7'd127, 32'h0);
    // successive hits on one slot
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h0A, 7'd99,  7'd33,  32'h0000_0100);
    send_event(CMD_EVENT, TYPE_NOTE_ON | 8'h0A, 7'd99,  7'd34,  32'h0000_0101);
    send_event(CMD_EVENT, TYPE_NOTE_OFF | 8'h0A, 7'd99, 7'd0,   32'h0000_0102);
    wait_drained();

    repeat (450) play_random_event();
    wait_drained();

    calm = 1'b1;
    repeat (250) play_random_event();
    calm = 1'b0;
    repeat (200) play_random_event();

    // many clears with notes in flight, enough to wrap the clear tag
    repeat (230) begin
      play_random_event();
      if ($urandom_range(1) == 1) play_random_event();
      send_clear();
    end
    repeat (120) play_random_event();

    wait_drained();
    if (tracker.fail_count == 0)
      $display("midi_note_span_pairing_top_tb passed");
    else
      $display("midi_note_span_pairing_top_tb failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/msnp_pkg.sv
rtl/core/msnp_ram.sv
rtl/core/midi_note_span_pairing_top.sv
tb/midi_note_span_pairing_top_tb.sv
